>>> hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Types, constants and round functions shared by the SHA-256 hasher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha256_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned HashN   = 8;
    localparam int unsigned BlockW  = 16;
    localparam int unsigned RoundN  = 64;
    localparam int unsigned LenW    = 64;
    localparam logic [4:0]  LenHiPos = 5'd14;
    localparam logic [7:0]  PadByte = 8'h80;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        message_end;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PAD,
        ST_ZERO,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_INIT,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic push_item;
        logic push_pad;
        logic push_zero;
        logic push_len_hi;
        logic push_len_lo;
        logic comp_init;
        logic comp_round;
        logic comp_final;
        logic emit;
        logic msg_reset;
    } t_cmd;

    typedef struct packed {
        logic       full;
        logic [3:0] wcnt;
        logic       last_round;
        logic       last_word;
    } t_stat;

    localparam logic [31:0] InitHash [HashN] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [RoundN] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

>>> hw/rtl/sha256_dp.sv
// ----------------------------------------------------------------------------
// sha256_dp
// Byte packer, 16-word schedule window, round unit, hash state and length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha256_pkg::t_in     i_in,
    input  sha256_pkg::t_cmd    i_cmd,
    output sha256_pkg::t_stat   o_stat,
    output sha256_pkg::t_out    o_out
);

    logic [23:0] r_acc;       // pending bytes, left aligned
    logic [1:0]  r_acc_n;
    logic [31:0] r_win [sha256_pkg::BlockW];
    logic [3:0]  r_wcnt;
    logic        r_full;
    logic [63:0] r_len;
    logic [31:0] r_h [sha256_pkg::HashN];
    logic [31:0] r_v [sha256_pkg::HashN];
    logic [5:0]  r_round;
    logic [2:0]  r_idx;

    logic [2:0]  n_cnt;
    logic [31:0] n_masked;
    logic [55:0] n_comb;
    logic [2:0]  n_total;
    logic        n_push;
    logic [31:0] n_word;
    logic [23:0] n_acc;
    logic [1:0]  n_acc_n;
    logic [31:0] n_sched;
    logic [31:0] n_t1;
    logic [31:0] n_t2;

    always_comb begin
        n_cnt    = (i_in.byte_count > 3'd4) ? 3'd4 : i_in.byte_count;
        n_masked = i_in.message_word & ~(32'hffffffff >> {n_cnt, 3'b000});
        n_comb   = {r_acc, 32'h0} | ({n_masked, 24'h0} >> {r_acc_n, 3'b000});
        n_total  = {1'b0, r_acc_n} + n_cnt;
        n_push   = 1'b0;
        n_word   = '0;
        n_acc    = r_acc;
        n_acc_n  = r_acc_n;
        priority if (i_cmd.push_item) begin
            if (n_total >= 3'd4) begin
                n_push  = 1'b1;
                n_word  = n_comb[55:24];
                n_acc   = n_comb[23:0];
                n_acc_n = 2'(n_total - 3'd4);
            end else begin
                n_acc   = n_comb[55:32];
                n_acc_n = n_total[1:0];
            end
        end else if (i_cmd.push_pad) begin
            n_push  = 1'b1;
            n_word  = {r_acc, 8'h0} | ({sha256_pkg::PadByte, 24'h0} >> {r_acc_n, 3'b000});
            n_acc   = '0;
            n_acc_n = 2'd0;
        end else if (i_cmd.push_zero) begin
            n_push = 1'b1;
        end else if (i_cmd.push_len_hi) begin
            n_push = 1'b1;
            n_word = r_len[63:32];
        end else if (i_cmd.push_len_lo) begin
            n_push = 1'b1;
            n_word = r_len[31:0];
        end else begin
            n_push = 1'b0;
        end
    end

    // window holds W[t..t+15]; next word from the fixed taps
    always_comb begin
        n_sched = sha256_pkg::sig1(r_win[14]) + r_win[9]
                + sha256_pkg::sig0(r_win[1]) + r_win[0];
        n_t1 = r_v[7] + sha256_pkg::bsig1(r_v[4])
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha256_pkg::RoundK[r_round] + r_win[0];
        n_t2 = sha256_pkg::bsig0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_acc_n <= '0;
            r_wcnt  <= '0;
            r_full  <= 1'b0;
            r_len   <= '0;
            r_round <= '0;
            r_idx   <= '0;
            for (int i = 0; i < sha256_pkg::HashN; i++) begin
                r_h[i] <= sha256_pkg::InitHash[i];
            end
        end else begin
            r_acc   <= n_acc;
            r_acc_n <= n_acc_n;
            if (i_cmd.push_item) begin
                r_len <= r_len + {58'h0, n_cnt, 3'b000};
            end
            if (n_push) begin
                r_win[r_wcnt] <= n_word;
                r_wcnt        <= r_wcnt + 4'd1;
                r_full        <= (r_wcnt == 4'd15);
            end
            if (i_cmd.comp_init) begin
                r_full  <= 1'b0;
                r_round <= '0;
                for (int i = 0; i < sha256_pkg::HashN; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
            if (i_cmd.comp_round) begin
                r_round <= r_round + 6'd1;
                for (int i = 0; i < sha256_pkg::BlockW - 1; i++) begin
                    r_win[i] <= r_win[i + 1];
                end
                r_win[sha256_pkg::BlockW - 1] <= n_sched;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + n_t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= n_t1 + n_t2;
            end
            if (i_cmd.comp_final) begin
                for (int i = 0; i < sha256_pkg::HashN; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.emit) begin
                r_idx <= r_idx + 3'd1;
            end
            // packer is already empty after the pad word
            if (i_cmd.msg_reset) begin
                r_wcnt  <= '0;
                r_len   <= '0;
                for (int i = 0; i < sha256_pkg::HashN; i++) begin
                    r_h[i] <= sha256_pkg::InitHash[i];
                end
            end
        end
    end

    assign o_stat.full       = r_full;
    assign o_stat.wcnt       = r_wcnt;
    assign o_stat.last_round = (r_round == 6'd63);
    assign o_stat.last_word  = (r_idx == 3'd7);

    assign o_out.digest_word = r_h[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.digest_last = (r_idx == 3'd7);

endmodule

>>> hw/rtl/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: absorb, pad, compress and digest readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_msg_end,
    input  logic                i_out_stall,
    input  sha256_pkg::t_stat   i_stat,
    output sha256_pkg::t_cmd    o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);

    sha256_pkg::t_state r_state, n_state;
    logic r_end, r_padded, r_lenp;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha256_pkg::ST_IDLE:   if (i_in_valid) n_state = sha256_pkg::ST_CHECK;
            sha256_pkg::ST_CHECK: begin
                priority if (i_stat.full)           n_state = sha256_pkg::ST_INIT;
                else if (!r_end)                    n_state = sha256_pkg::ST_IDLE;
                else if (!r_padded)                 n_state = sha256_pkg::ST_PAD;
                else if (r_lenp)                    n_state = sha256_pkg::ST_EMIT;
                else if (i_stat.wcnt == sha256_pkg::LenHiPos[3:0])
                                                    n_state = sha256_pkg::ST_LEN_HI;
                else                                n_state = sha256_pkg::ST_ZERO;
            end
            sha256_pkg::ST_PAD:    n_state = sha256_pkg::ST_CHECK;
            sha256_pkg::ST_ZERO:   n_state = sha256_pkg::ST_CHECK;
            sha256_pkg::ST_LEN_HI: n_state = sha256_pkg::ST_LEN_LO;
            sha256_pkg::ST_LEN_LO: n_state = sha256_pkg::ST_CHECK;
            sha256_pkg::ST_INIT:   n_state = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND:  if (i_stat.last_round) n_state = sha256_pkg::ST_FINAL;
            sha256_pkg::ST_FINAL:  n_state = sha256_pkg::ST_CHECK;
            sha256_pkg::ST_EMIT:
                if (!i_out_stall && i_stat.last_word) n_state = sha256_pkg::ST_IDLE;
            default:               n_state = sha256_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                o_in_stall      = 1'b0;
                o_cmd.push_item = i_in_valid;
            end
            sha256_pkg::ST_PAD:    o_cmd.push_pad    = 1'b1;
            sha256_pkg::ST_ZERO:   o_cmd.push_zero   = 1'b1;
            sha256_pkg::ST_LEN_HI: o_cmd.push_len_hi = 1'b1;
            sha256_pkg::ST_LEN_LO: o_cmd.push_len_lo = 1'b1;
            sha256_pkg::ST_INIT:   o_cmd.comp_init   = 1'b1;
            sha256_pkg::ST_ROUND:  o_cmd.comp_round  = 1'b1;
            sha256_pkg::ST_FINAL:  o_cmd.comp_final  = 1'b1;
            sha256_pkg::ST_EMIT: begin
                o_out_valid     = 1'b1;
                o_cmd.emit      = !i_out_stall;
                o_cmd.msg_reset = !i_out_stall && i_stat.last_word;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha256_pkg::ST_IDLE;
            r_end    <= 1'b0;
            r_padded <= 1'b0;
            r_lenp   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.push_item) begin
                r_end    <= i_msg_end;
                r_padded <= 1'b0;
                r_lenp   <= 1'b0;
            end
            if (o_cmd.push_pad)    r_padded <= 1'b1;
            if (o_cmd.push_len_lo) r_lenp   <= 1'b1;
        end
    end

endmodule

>>> hw/rtl/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher. Each input beat carries 0 to 4 message bytes
// (first byte in bits 31:24); a beat with message_end set closes the message,
// after which the block pads, finishes compression and returns eight digest
// beats, word 0 first, then starts a fresh message. It has a single round
// unit; each beat is followed by a status check, and a beat that fills a
// block stalls the input while the unit loads, runs 64 rounds and updates
// the hash, so no new beat is taken until that block is done. Closing a
// message costs up to two more compressions plus padding steps, and then
// the eight digest beats, one per cycle without stall.
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// Top level: controller and datapath of the SHA-256 hasher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_stream_hasher_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sha256_pkg::t_in     i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sha256_pkg::t_out    o_out_data
);

    sha256_pkg::t_cmd  cmd;
    sha256_pkg::t_stat stat;

    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_msg_end   (i_in_data.message_end),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    sha256_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_out   (o_out_data)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !o_out_valid)
        else $error("input beat taken during digest readout");

    a_block_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (stat.wcnt == 4'd0 && !stat.full))
        else $error("digest shown with a partial block");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.digest_last) |=> !o_out_valid)
        else $error("digest readout ran past the last word");

endmodule

>>> verif/sha256_stream_hasher_unit_checker.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit_checker
// Watches both channels, keeps its own SHA-256 state, predicts the digest beats
// of every closed message and compares them with the output beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  sha256_pkg::t_in     i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  sha256_pkg::t_out    i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic [31:0] IvTab [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] KTab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0]      hash_st [8];
    logic [7:0]       blk_bytes [64];
    int unsigned      blk_fill;
    logic [63:0]      msg_len_bits;
    sha256_pkg::t_out digest_q [$];
    int               fails;

    assign o_fail_count = fails;
    assign o_pending    = digest_q.size();

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
        for (int j = 0; j < 8; j++) v[j] = hash_st[j];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash_st[j] += v[j];
    endtask

    task automatic add_byte(logic [7:0] b);
        blk_bytes[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 64) begin
            compress();
            blk_fill = 0;
        end
    endtask

    task automatic absorb_beat(sha256_pkg::t_in d);
        int unsigned n;
        sha256_pkg::t_out w;
        logic [63:0] len;
        n = (d.byte_count > 3'd4) ? 4 : d.byte_count;
        for (int i = 0; i < n; i++) add_byte(d.message_word[31 - 8*i -: 8]);
        msg_len_bits += 64'(n * 8);
        if (d.message_end) begin
            len = msg_len_bits;
            add_byte(sha256_pkg::PadByte);
            while (blk_fill != 56) add_byte(8'h00);
            for (int i = 0; i < 8; i++) add_byte(len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                w.digest_word = hash_st[i];
                w.word_index  = 3'(i);
                w.digest_last = (i == 7);
                digest_q.push_back(w);
            end
            for (int j = 0; j < 8; j++) hash_st[j] = IvTab[j];
            msg_len_bits = '0;
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        fails++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    initial begin
        fails = 0;
        blk_fill = 0;
        msg_len_bits = '0;
        for (int j = 0; j < 8; j++) hash_st[j] = IvTab[j];
    end

    always @(posedge i_clk) begin
        sha256_pkg::t_out want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) absorb_beat(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (digest_q.size() == 0) begin
                    report("unexpected beat", i_out_data.digest_word, '0);
                end else begin
                    want = digest_q.pop_front();
                    if (i_out_data.digest_word !== want.digest_word)
                        report("digest_word", i_out_data.digest_word, want.digest_word);
                    if (i_out_data.word_index !== want.word_index)
                        report("word_index", 32'(i_out_data.word_index), 32'(want.word_index));
                    if (i_out_data.digest_last !== want.digest_last)
                        report("digest_last", 32'(i_out_data.digest_last),
                               32'(want.digest_last));
                end
            end
        end
    end
endmodule

>>> verif/sha256_stream_hasher_unit_tb.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit_tb
// Drives byte messages of varied length and shape into the hasher with random
// gaps and output stalls, including one long output hold-off; the checker
// predicts every digest and the top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    sha256_pkg::t_in  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    sha256_pkg::t_out out_data;
    int   fail_count;
    int   pending;
    bit   hold_off = 1'b0;
    int   beats_sent = 0;

    always #2 clk = ~clk;

    sha256_stream_hasher_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    sha256_stream_hasher_unit_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    task automatic send_beat(logic [31:0] word, logic [2:0] cnt, logic last, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 6) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{message_word: word, byte_count: cnt, message_end: last};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(int nbeats, bit gaps);
        logic [2:0] cnt;
        for (int i = 0; i < nbeats; i++) begin
            cnt = ($urandom_range(0, 9) < 7) ? 3'd4 : 3'($urandom_range(0, 7));
            send_beat($urandom, cnt, i == nbeats - 1, gaps);
        end
    endtask

    // receiver: random stalls, long hold-off on request
    initial begin
        int wait_n;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            wait_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
            out_stall <= (wait_n != 0);
            repeat (wait_n) @(negedge clk);
            out_stall <= 1'b0;
            @(negedge clk);
        end
    end

    initial begin
        #20ms;
        $display("sha256_stream_hasher_unit regression: fail");
        $finish;
    end

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty message, "abc", byte count saturation, ignored low bytes
        send_beat(32'hffffffff, 3'd0, 1'b1, 1'b0);
        send_beat(32'h616263ff, 3'd3, 1'b1, 1'b0);
        send_beat(32'h00000000, 3'd7, 1'b0, 1'b0);
        send_beat(32'hffffffff, 3'd5, 1'b0, 1'b0);
        send_beat(32'h12345678, 3'd6, 1'b0, 1'b0);
        send_beat(32'hdeadbeef, 3'd1, 1'b0, 1'b0);
        send_beat(32'habcdef01, 3'd2, 1'b0, 1'b0);
        send_beat(32'h55aa55aa, 3'd0, 1'b1, 1'b0);
        // 55 and 56 bytes: padding fits in one block vs needs a second
        for (int i = 0; i < 13; i++) send_beat($urandom, 3'd4, 1'b0, 1'b0);
        send_beat(32'hffffffff, 3'd3, 1'b1, 1'b0);
        for (int i = 0; i < 14; i++) send_beat(32'h80808080, 3'd4, 1'b0, 1'b0);
        send_beat(32'h01020304, 3'd0, 1'b1, 1'b0);

        // sender keeps offering beats while the receiver holds off
        hold_off = 1'b1;
        repeat (3) send_message(2, 1'b0);

        while (beats_sent < 250) begin
            case ($urandom_range(0, 4))
                0: send_message(1, 1'b1);
                1, 2: send_message($urandom_range(2, 8), 1'b1);
                3: send_message($urandom_range(14, 17), 1'b1);
                default: send_message($urandom_range(20, 40), 1'b1);
            endcase
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0) begin
            $display("sha256_stream_hasher_unit regression: pass");
        end else begin
            $display("sha256_stream_hasher_unit regression: fail");
        end
        $finish;
    end
endmodule
